// File: rtl/core/qas_pkg.sv
// shared types, character codes and escape mapping for the argument splitter
package qas_pkg;

   typedef enum logic [1:0] {
      MODE_IDLE   = 2'd0,
      MODE_PLAIN  = 2'd1,
      MODE_QUOTED = 2'd2
   } mode_type;

   localparam logic [7:0] CHAR_SPACE  = 8'h20;
   localparam logic [7:0] CHAR_QUOTE  = 8'h22;
   localparam logic [7:0] CHAR_BSLASH = 8'h5C;
   localparam logic [7:0] CHAR_B      = 8'h62;
   localparam logic [7:0] CHAR_F      = 8'h66;
   localparam logic [7:0] CHAR_N      = 8'h6E;
   localparam logic [7:0] CHAR_R      = 8'h72;
   localparam logic [7:0] CHAR_T      = 8'h74;
   localparam logic [7:0] CODE_BS     = 8'h08;
   localparam logic [7:0] CODE_FF     = 8'h0C;
   localparam logic [7:0] CODE_LF     = 8'h0A;
   localparam logic [7:0] CODE_CR     = 8'h0D;
   localparam logic [7:0] CODE_TAB    = 8'h09;

   typedef struct packed {
      logic [7:0] char_byte;
      logic       is_end;
   } req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       byte_valid;
      logic       arg_end;
      logic       string_done;
   } rsp_type;

   function automatic logic [7:0] map_escape(input logic [7:0] c);
      logic [7:0] r;
      case (c)
         CHAR_B:  r = CODE_BS;
         CHAR_F:  r = CODE_FF;
         CHAR_N:  r = CODE_LF;
         CHAR_R:  r = CODE_CR;
         CHAR_T:  r = CODE_TAB;
         default: r = c;
      endcase
      return r;
   endfunction

endpackage

// File: rtl/core/qas_in_stage.sv
// input register stage holding one request
module qas_in_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  logic             drain,
   input  qas_pkg::req_type req_in,
   output logic             valid,
   output qas_pkg::req_type req_out
);

   logic             valid_ff;
   logic             valid_in;
   qas_pkg::req_type data_ff;

   assign valid_in = load | (valid_ff & ~drain);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= req_in;
      end
   end

   assign valid   = valid_ff;
   assign req_out = data_ff;

endmodule

// File: rtl/core/qas_splitter.sv
// split state and per-byte decision logic
module qas_splitter (
   input  logic             clock,
   input  logic             reset,
   input  logic             step,
   input  qas_pkg::req_type req,
   output logic             has_rsp,
   output qas_pkg::rsp_type rsp
);

   qas_pkg::mode_type mode_ff;
   qas_pkg::mode_type mode_in;
   logic              escape_ff;
   logic              escape_in;

   always_comb begin
      mode_in   = mode_ff;
      escape_in = escape_ff;
      has_rsp   = 1'b0;
      rsp       = '0;
      if (req.is_end) begin
         // pending trailing backslash is simply dropped
         has_rsp         = 1'b1;
         rsp.arg_end     = (mode_ff != qas_pkg::MODE_IDLE);
         rsp.string_done = 1'b1;
         mode_in         = qas_pkg::MODE_IDLE;
         escape_in       = 1'b0;
      end else begin
         case (mode_ff)
            qas_pkg::MODE_IDLE: begin
               if (req.char_byte == qas_pkg::CHAR_QUOTE) begin
                  mode_in   = qas_pkg::MODE_QUOTED;
                  escape_in = 1'b0;
               end else if (req.char_byte != qas_pkg::CHAR_SPACE) begin
                  mode_in = qas_pkg::MODE_PLAIN;
                  if (req.char_byte == qas_pkg::CHAR_BSLASH) begin
                     escape_in = 1'b1;
                  end else begin
                     escape_in      = 1'b0;
                     has_rsp        = 1'b1;
                     rsp.out_byte   = req.char_byte;
                     rsp.byte_valid = 1'b1;
                  end
               end
            end
            default: begin
               if (escape_ff) begin
                  escape_in      = 1'b0;
                  has_rsp        = 1'b1;
                  rsp.out_byte   = qas_pkg::map_escape(req.char_byte);
                  rsp.byte_valid = 1'b1;
               end else if (req.char_byte == qas_pkg::CHAR_BSLASH) begin
                  escape_in = 1'b1;
               end else if ((mode_ff == qas_pkg::MODE_QUOTED &&
                             req.char_byte == qas_pkg::CHAR_QUOTE) ||
                            (mode_ff != qas_pkg::MODE_QUOTED &&
                             req.char_byte == qas_pkg::CHAR_SPACE)) begin
                  mode_in     = qas_pkg::MODE_IDLE;
                  has_rsp     = 1'b1;
                  rsp.arg_end = 1'b1;
               end else begin
                  has_rsp        = 1'b1;
                  rsp.out_byte   = req.char_byte;
                  rsp.byte_valid = 1'b1;
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff   <= qas_pkg::MODE_IDLE;
         escape_ff <= 1'b0;
      end else if (step) begin
         mode_ff   <= mode_in;
         escape_ff <= escape_in;
      end
   end

endmodule

// File: rtl/core/qas_out_stage.sv
// result register toward the response channel
module qas_out_stage (
   input  logic             clock,
   input  logic             reset,
   input  logic             load,
   input  qas_pkg::rsp_type rsp_in,
   input  logic             taken,
   output logic             valid,
   output qas_pkg::rsp_type rsp_out
);

   logic             valid_ff;
   logic             valid_in;
   qas_pkg::rsp_type data_ff;

   assign valid_in = load | (valid_ff & ~taken);

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= rsp_in;
      end
   end

   assign valid   = valid_ff;
   assign rsp_out = data_ff;

endmodule

// File: rtl/core/quoted_argument_splitter.sv
// top level of the quoted argument splitter
// Usage:
//   The request channel (req_*) carries one command line byte per request;
//   req_tlast marks the end-of-string request, whose byte is ignored.
//   The response channel (rsp_*) carries at most one response per request:
//   an unescaped argument byte (rsp_tuser[0] set), an argument end
//   (rsp_tlast set) or the end-of-string marker (rsp_tuser[1] set).
//   Requests that only change state (separating spaces, an opening quote,
//   a backslash) produce no response.
// Timing:
//   A request is registered on acceptance and decided against the split
//   state once the result register has room; its response is then
//   registered in the result register and offered on rsp_tvalid.
//   One request per cycle is sustained while rsp_tready stays high; the
//   split state is updated on each decision between the input and result registers.
// Reset and stalls:
//   Reset empties both registers and returns to idle between arguments.
//   While rsp_tready is low a valid response holds in the result register; one
//   more request is still taken into the input register if it is empty, then req_tready drops.
module quoted_argument_splitter (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  logic [7:0] req_tdata,   // [7:0] char_byte
   input  logic       req_tlast,   // is_end
   output logic       rsp_tvalid,
   input  logic       rsp_tready,
   output logic [7:0] rsp_tdata,   // [7:0] out_byte
   output logic [1:0] rsp_tuser,   // [0] byte_valid, [1] string_done
   output logic       rsp_tlast    // arg_end
);

   qas_pkg::req_type req_in;
   qas_pkg::req_type req_cur;
   qas_pkg::rsp_type rsp_dec;
   qas_pkg::rsp_type rsp_cur;
   logic             in_valid;
   logic             out_valid;
   logic             out_room;
   logic             step;
   logic             has_rsp;
   logic             req_fire;

   assign req_in.char_byte = req_tdata;
   assign req_in.is_end    = req_tlast;

   assign out_room   = ~out_valid | rsp_tready;
   assign step       = in_valid & out_room;
   assign req_tready = ~in_valid | step;
   assign req_fire   = req_tvalid & req_tready;

   qas_in_stage u_in (
      .clock   (clock),
      .reset   (reset),
      .load    (req_fire),
      .drain   (step),
      .req_in  (req_in),
      .valid   (in_valid),
      .req_out (req_cur)
   );

   qas_splitter u_split (
      .clock   (clock),
      .reset   (reset),
      .step    (step),
      .req     (req_cur),
      .has_rsp (has_rsp),
      .rsp     (rsp_dec)
   );

   qas_out_stage u_out (
      .clock   (clock),
      .reset   (reset),
      .load    (step & has_rsp),
      .rsp_in  (rsp_dec),
      .taken   (rsp_tready),
      .valid   (out_valid),
      .rsp_out (rsp_cur)
   );

   assign rsp_tvalid   = out_valid;
   assign rsp_tdata    = rsp_cur.out_byte;
   assign rsp_tuser[0] = rsp_cur.byte_valid;
   assign rsp_tuser[1] = rsp_cur.string_done;
   assign rsp_tlast    = rsp_cur.arg_end;

   // a response is never both a byte and an end marker
   a_kind_exclusive: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !(rsp_tuser[0] && (rsp_tuser[1] || rsp_tlast)))
      else $error("response carries a byte and an end marker");

   // marker responses carry a zero byte
   a_marker_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && !rsp_tuser[0]) |-> (rsp_tdata == 8'd0))
      else $error("marker response has nonzero byte");

   // an end-of-string request always yields a response when decided
   a_end_responds: assert property (@(posedge clock) disable iff (reset)
      (step && req_cur.is_end) |=> (rsp_tvalid && rsp_tuser[1]))
      else $error("end of string lost");

   // nothing is offered right after reset
   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

endmodule

// File: bench/tb_quoted_argument_splitter.sv
// self-checking bench for the quoted argument splitter: predicted responses vs stream output
module tb_quoted_argument_splitter;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_ITEMS = 1200;
   localparam int PRINT_LIMIT  = 40;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       req_tvalid = 1'b0;
   logic       req_tready;
   logic [7:0] req_tdata = 8'h00;   // [7:0] char_byte
   logic       req_tlast = 1'b0;    // is_end
   logic       rsp_tvalid;
   logic       rsp_tready = 1'b0;
   logic [7:0] rsp_tdata;           // [7:0] out_byte
   logic [1:0] rsp_tuser;           // [0] byte_valid, [1] string_done
   logic       rsp_tlast;           // arg_end

   qas_pkg::req_type  line_chars[$];
   qas_pkg::rsp_type  arg_pieces_due[$];
   qas_pkg::mode_type split_state = qas_pkg::MODE_IDLE;
   bit       escape_armed = 1'b0;
   int       error_count = 0;
   int       sent_count = 0;
   int       third_count = 1;
   int       stall_cycles = 0;
   int       send_idle_pct;
   int       recv_idle_pct;

   quoted_argument_splitter u_top (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast)
   );

   always #5 clock = ~clock;

   // sender busy first, receiver busy second, then full rate
   always_comb begin
      if (sent_count < third_count) begin
         send_idle_pct = 16;
         recv_idle_pct = 79;
      end else if (sent_count < 2 * third_count) begin
         send_idle_pct = 79;
         recv_idle_pct = 16;
      end else begin
         send_idle_pct = 0;
         recv_idle_pct = 0;
      end
   end

   task automatic report_error(input string msg);
      if (error_count < PRINT_LIMIT)
         $display("ERROR @%0t: %s", $time, msg);
      error_count++;
   endtask

   // advance the split state by one request; returns 1 when a response is due
   function automatic bit split_char(input qas_pkg::req_type r,
                                     output qas_pkg::rsp_type piece);
      logic [7:0] c;
      c = r.char_byte;
      piece = '0;
      if (r.is_end) begin
         piece.arg_end = (split_state != qas_pkg::MODE_IDLE);
         piece.string_done = 1'b1;
         split_state = qas_pkg::MODE_IDLE;
         escape_armed = 1'b0;
         return 1'b1;
      end
      if (split_state == qas_pkg::MODE_IDLE) begin
         if (c == qas_pkg::CHAR_SPACE)
            return 1'b0;
         if (c == qas_pkg::CHAR_QUOTE) begin
            split_state = qas_pkg::MODE_QUOTED;
            escape_armed = 1'b0;
            return 1'b0;
         end
         split_state = qas_pkg::MODE_PLAIN;
         escape_armed = (c == qas_pkg::CHAR_BSLASH);
         if (escape_armed)
            return 1'b0;
         piece.out_byte = c;
         piece.byte_valid = 1'b1;
         return 1'b1;
      end
      if (escape_armed) begin
         escape_armed = 1'b0;
         case (c)
            qas_pkg::CHAR_B:  piece.out_byte = qas_pkg::CODE_BS;
            qas_pkg::CHAR_F:  piece.out_byte = qas_pkg::CODE_FF;
            qas_pkg::CHAR_N:  piece.out_byte = qas_pkg::CODE_LF;
            qas_pkg::CHAR_R:  piece.out_byte = qas_pkg::CODE_CR;
            qas_pkg::CHAR_T:  piece.out_byte = qas_pkg::CODE_TAB;
            default:          piece.out_byte = c;
         endcase
         piece.byte_valid = 1'b1;
         return 1'b1;
      end
      if (c == qas_pkg::CHAR_BSLASH) begin
         escape_armed = 1'b1;
         return 1'b0;
      end
      // quotes close only quoted arguments, spaces only unquoted ones
      if ((split_state == qas_pkg::MODE_QUOTED && c == qas_pkg::CHAR_QUOTE) ||
          (split_state != qas_pkg::MODE_QUOTED && c == qas_pkg::CHAR_SPACE)) begin
         split_state = qas_pkg::MODE_IDLE;
         piece.arg_end = 1'b1;
         return 1'b1;
      end
      piece.out_byte = c;
      piece.byte_valid = 1'b1;
      return 1'b1;
   endfunction

   task automatic push_byte(input logic [7:0] c);
      qas_pkg::req_type r;
      r.char_byte = c;
      r.is_end = 1'b0;
      line_chars.push_back(r);
   endtask

   task automatic push_end(input logic [7:0] c);
      qas_pkg::req_type r;
      r.char_byte = c;
      r.is_end = 1'b1;
      line_chars.push_back(r);
   endtask

   function automatic logic [7:0] escape_letter();
      logic [7:0] c;
      case ($urandom_range(4))
         0:       c = qas_pkg::CHAR_B;
         1:       c = qas_pkg::CHAR_F;
         2:       c = qas_pkg::CHAR_N;
         3:       c = qas_pkg::CHAR_R;
         default: c = qas_pkg::CHAR_T;
      endcase
      return c;
   endfunction

   function automatic logic [7:0] noise_char();
      logic [7:0] c;
      case ($urandom_range(7))
         0:       c = qas_pkg::CHAR_SPACE;
         1:       c = qas_pkg::CHAR_QUOTE;
         2:       c = qas_pkg::CHAR_BSLASH;
         3:       c = escape_letter();
         4, 5:    c = 8'($urandom_range(255));
         default: c = 8'h61 + 8'($urandom_range(25));
      endcase
      return c;
   endfunction

   // argument content: separators are escaped so the argument stays whole
   task automatic push_arg_char();
      logic [7:0] c;
      c = noise_char();
      if (c == qas_pkg::CHAR_SPACE || c == qas_pkg::CHAR_QUOTE ||
          c == qas_pkg::CHAR_BSLASH) begin
         push_byte(qas_pkg::CHAR_BSLASH);
         push_byte(c);
      end else if ($urandom_range(3) == 0) begin
         push_byte(qas_pkg::CHAR_BSLASH);
         push_byte(escape_letter());
      end else begin
         push_byte(c);
      end
   endtask

   task automatic build_random_lines();
      int nargs;
      int len;
      while (line_chars.size() < RANDOM_ITEMS) begin
         if ($urandom_range(9) == 0) begin
            repeat ($urandom_range(12, 1)) push_byte(noise_char());
         end else begin
            nargs = $urandom_range(4);
            for (int a = 0; a < nargs; a++) begin
               repeat ($urandom_range(2, (a == 0) ? 0 : 1)) push_byte(qas_pkg::CHAR_SPACE);
               len = $urandom_range(6);
               if ($urandom_range(1)) begin
                  push_byte(qas_pkg::CHAR_QUOTE);
                  repeat (len) push_arg_char();
                  // now and then leave the quote open
                  if ($urandom_range(7) != 0)
                     push_byte(qas_pkg::CHAR_QUOTE);
               end else begin
                  repeat ((len == 0) ? 1 : len) push_arg_char();
               end
            end
            if ($urandom_range(3) == 0)
               push_byte(qas_pkg::CHAR_SPACE);
            else if ($urandom_range(7) == 0)
               push_byte(qas_pkg::CHAR_BSLASH);
         end
         push_end(8'($urandom_range(255)));
      end
   endtask

   initial begin
      // directed: separators, empty quoted argument, escapes, trailing backslash
      push_byte(qas_pkg::CHAR_SPACE);
      push_byte(8'h00);
      push_byte(qas_pkg::CHAR_QUOTE);
      push_byte(qas_pkg::CHAR_SPACE);
      push_byte(qas_pkg::CHAR_QUOTE);
      push_byte(qas_pkg::CHAR_QUOTE);
      push_byte(qas_pkg::CHAR_BSLASH);
      push_byte(qas_pkg::CHAR_B);
      push_byte(qas_pkg::CHAR_BSLASH);
      push_byte(qas_pkg::CHAR_F);
      push_byte(qas_pkg::CHAR_QUOTE);
      push_byte(qas_pkg::CHAR_SPACE);
      push_byte(qas_pkg::CHAR_BSLASH);
      push_byte(qas_pkg::CHAR_N);
      push_byte(qas_pkg::CHAR_BSLASH);
      push_byte(qas_pkg::CHAR_QUOTE);
      push_byte(8'hFF);
      push_end(8'hFF);
      push_end(8'h00);
      push_byte(qas_pkg::CHAR_BSLASH);
      push_byte(qas_pkg::CHAR_R);
      push_byte(qas_pkg::CHAR_BSLASH);
      push_byte(qas_pkg::CHAR_T);
      push_byte(qas_pkg::CHAR_BSLASH);
      push_end(qas_pkg::CHAR_BSLASH);
      build_random_lines();
      third_count = line_chars.size() / 3;

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      while (line_chars.size() != 0 || req_tvalid || arg_pieces_due.size() != 0)
         @(posedge clock);
      repeat (8) @(posedge clock);
      if (error_count == 0)
         $display("quoted_argument_splitter verification clean");
      else
         $display("quoted_argument_splitter verification failed");
      $finish;
   end

   // request driver
   always @(posedge clock) begin
      qas_pkg::rsp_type piece;
      qas_pkg::req_type r;
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) begin
            r.char_byte = req_tdata;
            r.is_end = req_tlast;
            if (split_char(r, piece))
               arg_pieces_due.push_back(piece);
            sent_count <= sent_count + 1;
         end
         if (!req_tvalid || req_tready) begin
            if (line_chars.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               r = line_chars.pop_front();
               req_tvalid <= 1'b1;
               req_tdata <= r.char_byte;
               req_tlast <= r.is_end;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // response monitor
   always @(posedge clock) begin
      qas_pkg::rsp_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            if (arg_pieces_due.size() == 0) begin
               report_error($sformatf("unexpected response data=%02h user=%b last=%b",
                                      rsp_tdata, rsp_tuser, rsp_tlast));
            end else begin
               want = arg_pieces_due.pop_front();
               if (rsp_tdata !== want.out_byte)
                  report_error($sformatf("out_byte %02h, expected %02h",
                                         rsp_tdata, want.out_byte));
               if (rsp_tuser[0] !== want.byte_valid)
                  report_error($sformatf("byte_valid %b, expected %b",
                                         rsp_tuser[0], want.byte_valid));
               if (rsp_tlast !== want.arg_end)
                  report_error($sformatf("arg_end %b, expected %b",
                                         rsp_tlast, want.arg_end));
               if (rsp_tuser[1] !== want.string_done)
                  report_error($sformatf("string_done %b, expected %b",
                                         rsp_tuser[1], want.string_done));
            end
         end
         rsp_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // no request or response moving for too long
   always @(posedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stall_cycles <= 0;
      end else if (stall_cycles >= STALL_LIMIT) begin
         $display("quoted_argument_splitter verification failed");
         $finish;
      end else begin
         stall_cycles <= stall_cycles + 1;
      end
   end

endmodule

// File: files.f
rtl/core/qas_pkg.sv
rtl/core/qas_in_stage.sv
rtl/core/qas_splitter.sv
rtl/core/qas_out_stage.sv
rtl/core/quoted_argument_splitter.sv
bench/tb_quoted_argument_splitter.sv
